FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/core/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Item types, op codes and fixed constants of the parallel resonator bank.
// ----------------------------------------------------------------------------
`default_nettype none

package prb_pkg;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] SEL_B0 = 2'd0;
  localparam logic [1:0] SEL_B1 = 2'd1;
  localparam logic [1:0] SEL_A1 = 2'd2;
  localparam logic [1:0] SEL_A2 = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] UNITY_Q16 = 17'd65536;

  localparam logic signed [23:0] SAT24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAT24_MIN = 24'sh800000;
  localparam logic signed [31:0] SAT32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] sample_in;
    logic [8:0]         coef_index;
    logic [1:0]         coef_select;
    logic signed [23:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mixed_out;
    logic signed [23:0] bank_sum;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/parallel_resonator_bank.sv
// ----------------------------------------------------------------------------
// parallel_resonator_bank
// Bank of second-order resonators driven by one sample, summed and mixed.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   prb_pkg::in_item_t
//   out      output     out_valid / out_ready prb_pkg::out_item_t
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// A sample item issues one resonator update per cycle through a pipelined
// datapath fed by single-port-read memories, then takes four mix steps.
// Coefficient writes and unused ops complete as they are taken; a clear
// zeroes the history memories entry by entry. After reset a sweep over all
// RESONATORS entries zeroes all memories before the first item is taken.
// A waiting result holds only the last mix step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module parallel_resonator_bank #(
  parameter int RESONATORS = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire prb_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output prb_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [prb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [prb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import prb_pkg::*;

  localparam int AW    = (RESONATORS > 1) ? $clog2(RESONATORS) : 1;
  localparam int SUM_W = 32 + $clog2(RESONATORS);
  localparam int PW    = SUM_W + 18;
  localparam int IW    = PW + 2;
  localparam int RW    = IW - 16;
  localparam int GW    = RW + 18;
  localparam int MW    = GW + 1 - 16;

  localparam logic signed [58:0]   HALF22   = 59'sh200000;
  localparam logic signed [IW-1:0] HALF16_I = IW'(17'sh08000);
  localparam logic signed [GW:0]   HALF16_G = (GW + 1)'(17'sh08000);
  localparam logic signed [17:0]   UNITY_S  = 18'sh10000;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RUN   = 7'b0000100,
    S_MIX_A = 7'b0001000,
    S_MIX_B = 7'b0010000,
    S_MIX_C = 7'b0100000,
    S_MIX_D = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] gain_r, wet_r;

  logic          clr_coef_r;
  logic [AW-1:0] clr_k_r;
  logic [AW-1:0] iss_k_r;
  logic          issuing_r;
  logic          p1_v_r, p2_v_r, p3_v_r;
  logic [AW-1:0] p1_k_r, p2_k_r, p3_k_r;

  logic signed [23:0] x_r, prev_in_r;

  logic signed [23:0] b0_mem [RESONATORS];
  logic signed [23:0] b1_mem [RESONATORS];
  logic signed [23:0] a1_mem [RESONATORS];
  logic signed [23:0] a2_mem [RESONATORS];
  logic signed [31:0] last_mem  [RESONATORS];
  logic signed [31:0] older_mem [RESONATORS];

  logic signed [23:0] b0_rd_r, b1_rd_r, a1_rd_r, a2_rd_r;
  logic signed [31:0] last_rd_r, older_rd_r;

  logic signed [55:0] pb0_r, pb1_r, pa1_r, pa2_r;
  logic signed [31:0] p2_last_r, p3_last_r;
  logic signed [57:0] acc_r;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [PW-1:0]    prod_wet_r;
  logic signed [41:0]      prod_dry_r;
  logic signed [RW-1:0]    inner_r;
  logic signed [GW-1:0]    gprod_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic in_fire, clearing, coef_write, idx_ok, out_load, drained;
  logic [AW-1:0] coef_waddr, hist_waddr, rd_addr;
  logic signed [23:0] coef_wdata;
  logic coef_we_b0, coef_we_b1, coef_we_a1, coef_we_a2, hist_we;
  logic signed [31:0] last_wdata, older_wdata;

  logic signed [58:0] acc_rnd;
  logic signed [36:0] y_wide;
  logic signed [31:0] y_sat;

  logic signed [17:0]   wet_s, dry_s, gain_s;
  logic signed [IW-1:0] inner_sum;
  logic signed [GW:0]   gsum;
  logic signed [MW-1:0] mix_wide;
  logic signed [23:0]   mix_sat, bank_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign drained   = !issuing_r && !p1_v_r && !p2_v_r && !p3_v_r;
  assign out_load  = (state_r == S_MIX_D) && (!out_valid_r || out_ready);

  assign idx_ok     = 32'(in_data.coef_index) < 32'(RESONATORS);
  assign coef_write = in_fire && (in_data.op == OP_COEF) && idx_ok;
  assign coef_waddr = clearing ? clr_k_r : AW'(in_data.coef_index);
  assign coef_wdata = clearing ? 24'sd0 : in_data.coef_value;
  assign coef_we_b0 = (clearing && clr_coef_r) || (coef_write && in_data.coef_select == SEL_B0);
  assign coef_we_b1 = (clearing && clr_coef_r) || (coef_write && in_data.coef_select == SEL_B1);
  assign coef_we_a1 = (clearing && clr_coef_r) || (coef_write && in_data.coef_select == SEL_A1);
  assign coef_we_a2 = (clearing && clr_coef_r) || (coef_write && in_data.coef_select == SEL_A2);

  assign hist_we     = clearing || p3_v_r;
  assign hist_waddr  = clearing ? clr_k_r : p3_k_r;
  assign last_wdata  = clearing ? 32'sd0 : y_sat;
  assign older_wdata = clearing ? 32'sd0 : p3_last_r;
  assign rd_addr     = iss_k_r;

  always_comb begin
    acc_rnd = 59'(acc_r) + HALF22;
    y_wide  = acc_rnd[58:22];
    if (y_wide > 37'(SAT32_MAX)) begin
      y_sat = SAT32_MAX;
    end else if (y_wide < 37'(SAT32_MIN)) begin
      y_sat = SAT32_MIN;
    end else begin
      y_sat = y_wide[31:0];
    end
  end

  always_comb begin
    wet_s     = $signed({1'b0, wet_r});
    gain_s    = $signed({1'b0, gain_r});
    dry_s     = wet_s - UNITY_S;
    inner_sum = IW'(prod_wet_r) + IW'(prod_dry_r) + HALF16_I;
    gsum      = (GW + 1)'(gprod_r) + HALF16_G;
    mix_wide  = gsum[GW:16];
    if (mix_wide > MW'(SAT24_MAX)) begin
      mix_sat = SAT24_MAX;
    end else if (mix_wide < MW'(SAT24_MIN)) begin
      mix_sat = SAT24_MIN;
    end else begin
      mix_sat = mix_wide[23:0];
    end
    if (sum_r > SUM_W'(SAT24_MAX)) begin
      bank_sat = SAT24_MAX;
    end else if (sum_r < SUM_W'(SAT24_MIN)) begin
      bank_sat = SAT24_MIN;
    end else begin
      bank_sat = sum_r[23:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_k_r == AW'(RESONATORS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire && in_data.op == OP_SAMPLE) begin
          state_nxt = S_RUN;
        end else if (in_fire && in_data.op == OP_CLEAR) begin
          state_nxt = S_CLEAR;
        end
      end
      S_RUN: begin
        if (drained) state_nxt = S_MIX_A;
      end
      S_MIX_A: state_nxt = S_MIX_B;
      S_MIX_B: state_nxt = S_MIX_C;
      S_MIX_C: state_nxt = S_MIX_D;
      S_MIX_D: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_coef_r  <= 1'b1;
      clr_k_r     <= '0;
      iss_k_r     <= '0;
      issuing_r   <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= UNITY_Q16;
      wet_r       <= UNITY_Q16;
      prev_in_r   <= 24'sd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAIN: gain_r <= cfg_wdata;
          CFG_WET:  wet_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (clearing) begin
        if (clr_k_r == AW'(RESONATORS - 1)) begin
          clr_coef_r <= 1'b0;
          clr_k_r    <= '0;
        end else begin
          clr_k_r <= clr_k_r + AW'(1);
        end
      end
      if (in_fire && in_data.op == OP_CLEAR) begin
        clr_k_r   <= '0;
        prev_in_r <= 24'sd0;
      end
      if (in_fire && in_data.op == OP_SAMPLE) begin
        iss_k_r   <= '0;
        issuing_r <= 1'b1;
      end else if (issuing_r) begin
        iss_k_r <= iss_k_r + AW'(1);
        if (iss_k_r == AW'(RESONATORS - 1)) issuing_r <= 1'b0;
      end
      p1_v_r <= issuing_r;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (state_r == S_RUN && drained) prev_in_r <= x_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we_b0) b0_mem[coef_waddr] <= coef_wdata;
    if (coef_we_b1) b1_mem[coef_waddr] <= coef_wdata;
    if (coef_we_a1) a1_mem[coef_waddr] <= coef_wdata;
    if (coef_we_a2) a2_mem[coef_waddr] <= coef_wdata;
    if (hist_we) begin
      last_mem[hist_waddr]  <= last_wdata;
      older_mem[hist_waddr] <= older_wdata;
    end
    b0_rd_r    <= b0_mem[rd_addr];
    b1_rd_r    <= b1_mem[rd_addr];
    a1_rd_r    <= a1_mem[rd_addr];
    a2_rd_r    <= a2_mem[rd_addr];
    last_rd_r  <= last_mem[rd_addr];
    older_rd_r <= older_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.op == OP_SAMPLE) begin
      x_r   <= in_data.sample_in;
      sum_r <= '0;
    end else if (p3_v_r) begin
      sum_r <= sum_r + SUM_W'(y_sat);
    end
    p1_k_r    <= iss_k_r;
    p2_k_r    <= p1_k_r;
    p3_k_r    <= p2_k_r;
    pb0_r     <= 56'(b0_rd_r) * 56'(x_r);
    pb1_r     <= 56'(b1_rd_r) * 56'(prev_in_r);
    pa1_r     <= 56'(a1_rd_r) * 56'(last_rd_r);
    pa2_r     <= 56'(a2_rd_r) * 56'(older_rd_r);
    p2_last_r <= last_rd_r;
    acc_r     <= 58'(pb0_r) + 58'(pb1_r) - 58'(pa1_r) - 58'(pa2_r);
    p3_last_r <= p2_last_r;
    if (state_r == S_MIX_A) begin
      prod_wet_r <= PW'(sum_r) * PW'(wet_s);
      prod_dry_r <= 42'(dry_s) * 42'(x_r);
    end
    if (state_r == S_MIX_B) inner_r <= inner_sum[IW-1:16];
    if (state_r == S_MIX_C) gprod_r <= GW'(inner_r) * GW'(gain_s);
    if (out_load) begin
      out_data_r.mixed_out <= mix_sat;
      out_data_r.bank_sum  <= bank_sat;
    end
  end

  `ASSERT_IMPLY(a_pipe_only_in_run, p1_v_r || p2_v_r || p3_v_r, state_r == S_RUN)
  `ASSERT_IMPLY(a_issue_in_range, issuing_r, 32'(iss_k_r) < 32'(RESONATORS))
  `ASSERT_NEXT(a_sample_starts_run, in_fire && in_data.op == OP_SAMPLE, state_r == S_RUN)

endmodule

`default_nettype wire
